[hdl/ftks_pkg.sv]
package ftks_pkg;

    localparam int ID_W     = 31;
    localparam int RATING_W = 16;
    localparam int COUNT_W  = 5;
    localparam int RANK_W   = 5;
    localparam int CFG_IDX_W = 1;
    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_USER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_COUNT   = 1'd1;

    typedef struct packed {
        logic [ID_W-1:0]     reviewer_id;
        logic [ID_W-1:0]     item_id;
        logic [RATING_W-1:0] rating;
        logic                end_of_list;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0]     best_item;
        logic [RATING_W-1:0] best_rating;
        logic [RANK_W-1:0]   rank;
        logic                last_result;
    } result_t;

    typedef struct packed {
        logic [ID_W-1:0]     item_id;
        logic [RATING_W-1:0] rating;
        logic                hit;
        logic                last;
    } q_entry_t;

    typedef struct packed {
        logic     push;
        q_entry_t entry;
    } q_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

[hdl/filtered_top_k_selector_top.sv]
// channel   direction  handshake                      payload
// item      in         start & !busy                  ftks_pkg::in_item_t
// result    out        result_valid, one cycle        ftks_pkg::result_t
// config    in         cfg_valid & cfg_ready          cfg_index, cfg_data
//
// One record per cycle is taken while busy is low; hits and closing records
// enter a 4-deep queue. The sorter drains one per cycle outside emission,
// comparing against all kept entries in parallel. A closing record starts
// emission of the kept entries, one result per cycle; the queue holds
// arrivals meanwhile and busy rises when it is full. The result port cannot
// be stalled. Reset is asynchronous: table empty, target_user 0, top_count 20.
module filtered_top_k_selector_top
#(
    parameter int MAX_KEPT = 20
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  ftks_pkg::in_item_t                   item,
    output ftks_pkg::result_t                    result,
    output logic                                 result_valid,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ftks_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ftks_pkg::ID_W-1:0]            cfg_data
);

    logic [ftks_pkg::ID_W-1:0]    target_user_reg;
    logic [ftks_pkg::COUNT_W-1:0] top_count_reg;

    ftks_pkg::q_push_t   q_push;
    ftks_pkg::q_status_t q_status;
    ftks_pkg::q_entry_t  head;
    logic                pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_user_reg <= '0;
            top_count_reg   <= ftks_pkg::COUNT_W'(20);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ftks_pkg::CFG_TARGET_USER:
                begin
                    target_user_reg <= cfg_data;
                end
                ftks_pkg::CFG_TOP_COUNT:
                begin
                    top_count_reg <= cfg_data[ftks_pkg::COUNT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    ftks_front u_front
    (
        .start       (start),
        .item        (item),
        .target_user (target_user_reg),
        .q_status    (q_status),
        .busy        (busy),
        .q_push      (q_push)
    );

    ftks_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_push   (q_push),
        .pop      (pop),
        .head     (head),
        .q_status (q_status)
    );

    ftks_back
    #(
        .MAX_KEPT (MAX_KEPT)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .top_count    (top_count_reg),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

[hdl/ftks_front.sv]
module ftks_front
(
    input  logic                          start,
    input  ftks_pkg::in_item_t            item,
    input  logic [ftks_pkg::ID_W-1:0]     target_user,
    input  ftks_pkg::q_status_t           q_status,
    output logic                          busy,
    output ftks_pkg::q_push_t             q_push
);

    logic hit;

    assign hit  = (item.reviewer_id == target_user);
    assign busy = q_status.full;

    // non-matching records that do not close the list carry no work
    always_comb
    begin
        q_push.push          = start && !q_status.full && (hit || item.end_of_list);
        q_push.entry.item_id = item.item_id;
        q_push.entry.rating  = item.rating;
        q_push.entry.hit     = hit;
        q_push.entry.last    = item.end_of_list;
    end

endmodule

[hdl/ftks_queue.sv]
module ftks_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ftks_pkg::q_push_t     q_push,
    input  logic                  pop,
    output ftks_pkg::q_entry_t    head,
    output ftks_pkg::q_status_t   q_status
);

    ftks_pkg::q_entry_t mem [ftks_pkg::Q_DEPTH];

    logic [ftks_pkg::Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ftks_pkg::Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ftks_pkg::Q_PTR_W:0]   fill_reg, fill_next;
    logic                         do_pop;

    assign q_status.full  = (fill_reg == (ftks_pkg::Q_PTR_W+1)'(ftks_pkg::Q_DEPTH));
    assign q_status.empty = (fill_reg == '0);
    assign do_pop         = pop && !q_status.empty;
    assign head           = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (q_push.push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (q_push.push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!q_push.push && do_pop)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push.push)
        begin
            mem[wr_ptr_reg] <= q_push.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

[hdl/ftks_back.sv]
module ftks_back
#(
    parameter int MAX_KEPT = 20
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [ftks_pkg::COUNT_W-1:0]      top_count,
    input  ftks_pkg::q_entry_t                head,
    input  ftks_pkg::q_status_t               q_status,
    output logic                              pop,
    output ftks_pkg::result_t                 result,
    output logic                              result_valid
);

    localparam int CW = $clog2(MAX_KEPT + 1);

    localparam logic ST_RUN  = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic                            state_reg, state_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [CW-1:0]                   rank_reg, rank_next;
    logic [ftks_pkg::ID_W-1:0]       items_reg [MAX_KEPT];
    logic [ftks_pkg::ID_W-1:0]       items_next [MAX_KEPT];
    logic [ftks_pkg::RATING_W-1:0]   ratings_reg [MAX_KEPT];
    logic [ftks_pkg::RATING_W-1:0]   ratings_next [MAX_KEPT];
    ftks_pkg::result_t               result_reg, result_next;
    logic                            result_valid_reg, result_valid_next;

    logic [CW-1:0]                   lim;
    logic [CW-1:0]                   n_eff;
    logic [CW-1:0]                   n_after;
    logic [MAX_KEPT-1:0]             ge;
    logic                            at_lim_ge;
    logic                            do_insert;
    logic                            emit_last;

    assign pop          = (state_reg == ST_RUN) && !q_status.empty;
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    always_comb
    begin
        if (top_count == '0)
        begin
            lim = CW'(1);
        end
        else if (32'(top_count) > 32'(MAX_KEPT))
        begin
            lim = CW'(MAX_KEPT);
        end
        else
        begin
            lim = CW'(top_count);
        end
        n_eff = (count_reg > lim) ? lim : count_reg;
    end

    // parallel compare against every kept entry; ge is a prefix of the table
    always_comb
    begin
        at_lim_ge = 1'b0;
        for (int j = 0; j < MAX_KEPT; j++)
        begin
            ge[j] = (CW'(j) < n_eff) && (ratings_reg[j] >= head.rating);
            if (ge[j] && (CW'(j + 1) == lim))
            begin
                at_lim_ge = 1'b1;
            end
        end
        do_insert = pop && head.hit && !at_lim_ge;
        n_after   = (do_insert && (n_eff < lim)) ? n_eff + 1'b1 : n_eff;
    end

    assign emit_last = (CW'(rank_reg + 1'b1) == count_reg);

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        rank_next         = rank_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        for (int j = 0; j < MAX_KEPT; j++)
        begin
            items_next[j]   = items_reg[j];
            ratings_next[j] = ratings_reg[j];
        end

        unique case (state_reg)
            ST_RUN:
            begin
                if (pop)
                begin
                    if (do_insert)
                    begin
                        for (int j = 0; j < MAX_KEPT; j++)
                        begin
                            if (!ge[j])
                            begin
                                if (j == 0 || ge[(j == 0) ? 0 : j - 1])
                                begin
                                    items_next[j]   = head.item_id;
                                    ratings_next[j] = head.rating;
                                end
                                else
                                begin
                                    items_next[j]   = items_reg[(j == 0) ? 0 : j - 1];
                                    ratings_next[j] = ratings_reg[(j == 0) ? 0 : j - 1];
                                end
                            end
                        end
                    end
                    count_next = n_after;
                    rank_next  = '0;
                    if (head.last && (n_after != '0))
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                result_next.best_item   = items_reg[0];
                result_next.best_rating = ratings_reg[0];
                result_next.rank        = ftks_pkg::RANK_W'(rank_reg);
                result_next.last_result = emit_last;
                result_valid_next       = 1'b1;
                for (int j = 0; j < MAX_KEPT - 1; j++)
                begin
                    items_next[j]   = items_reg[j + 1];
                    ratings_next[j] = ratings_reg[j + 1];
                end
                rank_next = rank_reg + 1'b1;
                if (emit_last)
                begin
                    count_next = '0;
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < MAX_KEPT; j++)
        begin
            items_reg[j]   <= items_next[j];
            ratings_reg[j] <= ratings_next[j];
        end
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_RUN;
            count_reg        <= '0;
            rank_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            rank_reg         <= rank_next;
            result_valid_reg <= result_valid_next;
        end
    end

endmodule
